// ===== hw/rtl/mtr_pkg.sv =====
// Package with shared types, register offsets and sizes for the multichannel timer.
package mtr_pkg;

    localparam int NUM_CHANNELS = 20;
    localparam int COUNT_WIDTH  = 32;
    localparam int DATA_W       = 32;
    localparam int ADDR_W       = 10;
    localparam int KIND_W       = 2;
    localparam int CH_IDX_W     = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int RATIO_W      = 8;
    localparam int DIV_LSB      = 8;
    localparam int DIV_ON_BIT   = 17;

    localparam logic [KIND_W-1:0] KIND_TICK  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_WRITE = 2'd2;

    localparam logic [ADDR_W-1:0] REG_DEST   = 10'h000;
    localparam logic [ADDR_W-1:0] REG_STATUS = 10'h010;
    localparam logic [ADDR_W-1:0] REG_INTEN  = 10'h020;
    localparam logic [ADDR_W-1:0] REG_CLKDIV = 10'h030;
    localparam logic [ADDR_W-1:0] CHAN_BASE  = 10'h100;

    localparam logic [3:0] CHAN_REG_CTRL   = 4'h0;
    localparam logic [3:0] CHAN_REG_TARGET = 4'h4;
    localparam logic [3:0] CHAN_REG_COUNT  = 4'h8;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ADDR_W-1:0] address;
        logic [DATA_W-1:0] write_data;
    } req_t;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              mapped;
        logic              irq;
    } rsp_t;

    typedef struct packed {
        logic tick;
        logic div_tick;
        logic ctrl_we;
        logic target_we;
    } chan_cmd_t;

    typedef struct packed {
        logic enable;
        logic periodic;
        logic use_div;
    } chan_ctrl_t;

endpackage

// ===== hw/rtl/mtr_channel.sv =====
// One timer channel: control bits, target, up counter and expiry detection.
module mtr_channel
    import mtr_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  chan_cmd_t              cmd,
    input  logic [DATA_W-1:0]      write_data,
    output chan_ctrl_t             ctrl,
    output logic [COUNT_WIDTH-1:0] target,
    output logic [COUNT_WIDTH-1:0] count,
    output logic                   expire
);

    chan_ctrl_t             ctrl_reg;
    chan_ctrl_t             ctrl_next;
    logic [COUNT_WIDTH-1:0] target_reg;
    logic [COUNT_WIDTH-1:0] target_next;
    logic [COUNT_WIDTH-1:0] count_reg;
    logic [COUNT_WIDTH-1:0] count_next;
    logic                   counting;

    always_comb
    begin
        ctrl_next   = ctrl_reg;
        target_next = target_reg;
        count_next  = count_reg;
        counting    = cmd.tick && ctrl_reg.enable && (!ctrl_reg.use_div || cmd.div_tick);
        expire      = 1'b0;

        if (counting)
        begin
            if (count_reg == target_reg)
            begin
                expire = 1'b1;
                if (ctrl_reg.periodic)
                begin
                    count_next = '0;
                end
                else
                begin
                    ctrl_next.enable = 1'b0;
                end
            end
            else
            begin
                count_next = count_reg + COUNT_WIDTH'(1);
            end
        end

        if (cmd.ctrl_we)
        begin
            // Turning a stopped channel on restarts its counter.
            if (write_data[0] && !ctrl_reg.enable)
            begin
                count_next = '0;
            end
            ctrl_next.enable   = write_data[0];
            ctrl_next.periodic = write_data[1];
            ctrl_next.use_div  = write_data[2];
        end

        if (cmd.target_we)
        begin
            target_next = write_data[COUNT_WIDTH-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg   <= '0;
            target_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            ctrl_reg   <= ctrl_next;
            target_reg <= target_next;
            count_reg  <= count_next;
        end
    end

    assign ctrl   = ctrl_reg;
    assign target = target_reg;
    assign count  = count_reg;

endmodule

// ===== hw/rtl/multichannel_timer_registers_top.sv =====
// Top level of the multichannel timer: request register, register file and response register.
// A request waits in the request register, and its response is held in the response register until taken.
// Throughput: one request per cycle while responses are taken; all channels count in parallel on a tick.
// The response register lets a new request enter while a response waits.
// Reset is asynchronous and active low and clears every register and counter but the request and response data.
module multichannel_timer_registers_top
    import mtr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req_data,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp_data
);

    logic                    req_valid_reg;
    req_t                    req_data_reg;
    logic                    rsp_valid_reg;
    rsp_t                    rsp_data_reg;
    rsp_t                    rsp_data_next;
    logic                    advance;

    logic [NUM_CHANNELS-1:0] expired_reg;
    logic [NUM_CHANNELS-1:0] expired_next;
    logic [NUM_CHANNELS-1:0] irq_en_reg;
    logic [NUM_CHANNELS-1:0] irq_en_next;
    logic [NUM_CHANNELS-1:0] routes_reg;
    logic [NUM_CHANNELS-1:0] routes_next;
    logic [RATIO_W-1:0]      ratio_reg;
    logic [RATIO_W-1:0]      ratio_next;
    logic                    div_on_reg;
    logic                    div_on_next;
    logic [RATIO_W-1:0]      prescale_reg;
    logic [RATIO_W-1:0]      prescale_next;

    logic                    is_tick;
    logic                    is_read;
    logic                    is_write;
    logic                    div_tick;
    logic [ADDR_W-5:0]       ch_full;
    logic [CH_IDX_W-1:0]     ch_idx;
    logic                    ch_hit;
    logic [3:0]              ch_reg;
    logic [DATA_W-1:0]       wdata;

    chan_cmd_t               cmd     [NUM_CHANNELS];
    chan_ctrl_t              ctrl    [NUM_CHANNELS];
    logic [COUNT_WIDTH-1:0]  target  [NUM_CHANNELS];
    logic [COUNT_WIDTH-1:0]  count   [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] expire;

    assign advance   = req_valid_reg && (!rsp_valid_reg || rsp_ready);
    assign req_ready = !req_valid_reg || advance;
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

    assign is_tick  = advance && (req_data_reg.kind == KIND_TICK);
    assign is_read  = advance && (req_data_reg.kind == KIND_READ);
    assign is_write = advance && (req_data_reg.kind == KIND_WRITE);
    assign wdata    = req_data_reg.write_data;

    assign div_tick = div_on_reg && (prescale_reg >= ratio_reg);

    // Channel windows start at the channel base, sixteen bytes apiece.
    assign ch_full = req_data_reg.address[ADDR_W-1:4] - CHAN_BASE[ADDR_W-1:4];
    assign ch_idx  = ch_full[CH_IDX_W-1:0];
    assign ch_reg  = req_data_reg.address[3:0];
    assign ch_hit  = (req_data_reg.address >= CHAN_BASE)
                     && (32'(ch_full) < 32'(NUM_CHANNELS));

    for (genvar i = 0; i < NUM_CHANNELS; i++)
    begin : g_chan
        logic sel;

        assign sel = ch_hit && (ch_idx == CH_IDX_W'(i)) && is_write;

        assign cmd[i].tick      = is_tick;
        assign cmd[i].div_tick  = div_tick;
        assign cmd[i].ctrl_we   = sel && (ch_reg == CHAN_REG_CTRL);
        assign cmd[i].target_we = sel && (ch_reg == CHAN_REG_TARGET);

        mtr_channel u_chan
        (
            .clk        (clk),
            .rst_n      (rst_n),
            .cmd        (cmd[i]),
            .write_data (wdata),
            .ctrl       (ctrl[i]),
            .target     (target[i]),
            .count      (count[i]),
            .expire     (expire[i])
        );
    end

    always_comb
    begin
        expired_next  = expired_reg;
        irq_en_next   = irq_en_reg;
        routes_next   = routes_reg;
        ratio_next    = ratio_reg;
        div_on_next   = div_on_reg;
        prescale_next = prescale_reg;
        rsp_data_next = '0;

        if (is_tick)
        begin
            if (!div_on_reg || div_tick)
            begin
                prescale_next = '0;
            end
            else
            begin
                prescale_next = prescale_reg + RATIO_W'(1);
            end
            expired_next = expired_reg | expire;
        end

        if ((is_read || is_write) && (req_data_reg.address[1:0] == 2'b00))
        begin
            if (req_data_reg.address < CHAN_BASE)
            begin
                case (req_data_reg.address)
                    REG_DEST:
                    begin
                        rsp_data_next.mapped = 1'b1;
                        if (is_write)
                        begin
                            routes_next = wdata[NUM_CHANNELS-1:0];
                        end
                        else
                        begin
                            rsp_data_next.read_data = DATA_W'(routes_reg);
                        end
                    end
                    REG_STATUS:
                    begin
                        rsp_data_next.mapped = 1'b1;
                        if (is_write)
                        begin
                            expired_next = expired_reg & ~wdata[NUM_CHANNELS-1:0];
                        end
                        else
                        begin
                            rsp_data_next.read_data = DATA_W'(expired_reg);
                        end
                    end
                    REG_INTEN:
                    begin
                        rsp_data_next.mapped = 1'b1;
                        if (is_write)
                        begin
                            irq_en_next = wdata[NUM_CHANNELS-1:0];
                        end
                        else
                        begin
                            rsp_data_next.read_data = DATA_W'(irq_en_reg);
                        end
                    end
                    REG_CLKDIV:
                    begin
                        rsp_data_next.mapped = 1'b1;
                        if (is_write)
                        begin
                            ratio_next    = wdata[DIV_LSB +: RATIO_W];
                            div_on_next   = wdata[DIV_ON_BIT];
                            prescale_next = '0;
                        end
                        else
                        begin
                            rsp_data_next.read_data[DIV_LSB +: RATIO_W] = ratio_reg;
                            rsp_data_next.read_data[DIV_ON_BIT]         = div_on_reg;
                        end
                    end
                    default:
                    begin
                        rsp_data_next.mapped = 1'b0;
                    end
                endcase
            end
            else if (ch_hit)
            begin
                case (ch_reg)
                    CHAN_REG_CTRL:
                    begin
                        rsp_data_next.mapped = 1'b1;
                        if (is_read)
                        begin
                            rsp_data_next.read_data = DATA_W'({ctrl[ch_idx].use_div,
                                                               ctrl[ch_idx].periodic,
                                                               ctrl[ch_idx].enable});
                        end
                    end
                    CHAN_REG_TARGET:
                    begin
                        rsp_data_next.mapped = 1'b1;
                        if (is_read)
                        begin
                            rsp_data_next.read_data = DATA_W'(target[ch_idx]);
                        end
                    end
                    CHAN_REG_COUNT:
                    begin
                        rsp_data_next.mapped = 1'b1;
                        if (is_read)
                        begin
                            rsp_data_next.read_data = DATA_W'(count[ch_idx]);
                        end
                    end
                    default:
                    begin
                        rsp_data_next.mapped = 1'b0;
                    end
                endcase
            end
        end

        rsp_data_next.irq = |(expired_next & irq_en_next & routes_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
            expired_reg   <= '0;
            irq_en_reg    <= '0;
            routes_reg    <= '0;
            ratio_reg     <= '0;
            div_on_reg    <= 1'b0;
            prescale_reg  <= '0;
        end
        else
        begin
            if (req_ready)
            begin
                req_valid_reg <= req_valid;
            end
            if (advance)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
            expired_reg  <= expired_next;
            irq_en_reg   <= irq_en_next;
            routes_reg   <= routes_next;
            ratio_reg    <= ratio_next;
            div_on_reg   <= div_on_next;
            prescale_reg <= prescale_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            req_data_reg <= req_data;
        end
        if (advance)
        begin
            rsp_data_reg <= rsp_data_next;
        end
    end

    // The interrupt in a response matches the registers it leaves behind.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (rsp_data_reg.irq == |(expired_reg & irq_en_reg & routes_reg)))
    else $error("response irq does not match the interrupt registers");

    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && !rsp_data_reg.mapped) |-> (rsp_data_reg.read_data == '0))
    else $error("unmapped response carries read data");

    assert property (@(posedge clk) disable iff (!rst_n)
        !div_on_reg |-> (prescale_reg == '0))
    else $error("prescaler runs while the divider is off");

    assert property (@(posedge clk) disable iff (!rst_n)
        prescale_reg <= ratio_reg)
    else $error("prescaler passed the divider ratio");

    assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid_reg && !advance) |=> (req_valid_reg && $stable(req_data_reg)))
    else $error("held request was lost or changed");

endmodule

// ===== verif/timer_register_checker.sv =====
`timescale 1ns / 1ps
// Checker for the multichannel timer: tracks timer state from accepted requests and checks every response.
module timer_register_checker
    import mtr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    input  logic req_ready,
    input  req_t req_data,
    input  logic rsp_valid,
    input  logic rsp_ready,
    input  rsp_t rsp_data,
    output int   failures,
    output int   pending,
    output int   checked
);

    logic                    chan_on       [NUM_CHANNELS];
    logic                    chan_repeat   [NUM_CHANNELS];
    logic                    chan_divided  [NUM_CHANNELS];
    logic [COUNT_WIDTH-1:0]  chan_limit    [NUM_CHANNELS];
    logic [COUNT_WIDTH-1:0]  chan_value    [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] expired;
    logic [NUM_CHANNELS-1:0] irq_mask;
    logic [NUM_CHANNELS-1:0] irq_route;
    logic [RATIO_W-1:0]      ratio;
    logic [RATIO_W-1:0]      prescale;
    logic                    div_on;

    rsp_t expected_rsp[$];
    rsp_t oldest;
    int   fail_total;
    int   compared;

    function automatic void advance_tick();
        logic div_tick;
        div_tick = 1'b0;
        if (div_on)
        begin
            if (prescale >= ratio)
            begin
                div_tick = 1'b1;
                prescale = '0;
            end
            else
                prescale = prescale + 1'b1;
        end
        else
            prescale = '0;
        for (int ch = 0; ch < NUM_CHANNELS; ch++)
        begin
            if (chan_on[ch] && (!chan_divided[ch] || div_tick))
            begin
                if (chan_value[ch] == chan_limit[ch])
                begin
                    expired[ch] = 1'b1;
                    if (chan_repeat[ch])
                        chan_value[ch] = '0;
                    else
                        chan_on[ch] = 1'b0;
                end
                else
                    chan_value[ch] = chan_value[ch] + 1'b1;
            end
        end
    endfunction

    function automatic rsp_t predict_response(req_t r);
        rsp_t              o;
        logic              wr;
        logic [ADDR_W-1:0] off;
        logic [DATA_W-1:0] wd;
        int                ch;
        o  = '0;
        wd = r.write_data;
        wr = (r.kind == KIND_WRITE);
        if (r.kind == KIND_TICK)
            advance_tick();
        else if ((r.kind == KIND_READ || wr) && r.address[1:0] == 2'b00)
        begin
            if (r.address < CHAN_BASE)
            begin
                o.mapped = 1'b1;
                case (r.address)
                    REG_DEST:
                        if (wr) irq_route = wd[NUM_CHANNELS-1:0];
                        else o.read_data = DATA_W'(irq_route);
                    REG_STATUS:
                        if (wr) expired = expired & ~wd[NUM_CHANNELS-1:0];
                        else o.read_data = DATA_W'(expired);
                    REG_INTEN:
                        if (wr) irq_mask = wd[NUM_CHANNELS-1:0];
                        else o.read_data = DATA_W'(irq_mask);
                    REG_CLKDIV:
                        if (wr)
                        begin
                            ratio    = wd[DIV_LSB +: RATIO_W];
                            div_on   = wd[DIV_ON_BIT];
                            prescale = '0;
                        end
                        else
                        begin
                            o.read_data[DIV_LSB +: RATIO_W] = ratio;
                            o.read_data[DIV_ON_BIT]         = div_on;
                        end
                    default:
                        o.mapped = 1'b0;
                endcase
            end
            else
            begin
                off = r.address - CHAN_BASE;
                ch  = int'(off >> 4);
                if (ch < NUM_CHANNELS)
                begin
                    o.mapped = 1'b1;
                    case (off[3:0])
                        CHAN_REG_CTRL:
                            if (wr)
                            begin
                                if (wd[0] && !chan_on[ch])
                                    chan_value[ch] = '0;
                                chan_on[ch]      = wd[0];
                                chan_repeat[ch]  = wd[1];
                                chan_divided[ch] = wd[2];
                            end
                            else
                                o.read_data = DATA_W'({chan_divided[ch], chan_repeat[ch],
                                                       chan_on[ch]});
                        CHAN_REG_TARGET:
                            if (wr) chan_limit[ch] = wd[COUNT_WIDTH-1:0];
                            else o.read_data = DATA_W'(chan_limit[ch]);
                        CHAN_REG_COUNT:
                            if (!wr) o.read_data = DATA_W'(chan_value[ch]);
                        default:
                            o.mapped = 1'b0;
                    endcase
                end
            end
        end
        o.irq = |(expired & irq_mask & irq_route);
        return o;
    endfunction

    task automatic flag_field(string name, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
        if (fail_total < 40)
            $error("%s: expected %h, got %h", name, want, got);
        fail_total++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int ch = 0; ch < NUM_CHANNELS; ch++)
            begin
                chan_on[ch]      = 1'b0;
                chan_repeat[ch]  = 1'b0;
                chan_divided[ch] = 1'b0;
                chan_limit[ch]   = '0;
                chan_value[ch]   = '0;
            end
            expired    = '0;
            irq_mask   = '0;
            irq_route  = '0;
            ratio      = '0;
            prescale   = '0;
            div_on     = 1'b0;
            expected_rsp.delete();
            fail_total = 0;
            compared   = 0;
        end
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (expected_rsp.size() == 0)
                begin
                    if (fail_total < 40)
                        $error("response arrived with no request outstanding");
                    fail_total++;
                end
                else
                begin
                    oldest = expected_rsp.pop_front();
                    compared++;
                    if (rsp_data.read_data !== oldest.read_data)
                        flag_field("read_data", oldest.read_data, rsp_data.read_data);
                    if (rsp_data.mapped !== oldest.mapped)
                        flag_field("mapped", DATA_W'(oldest.mapped), DATA_W'(rsp_data.mapped));
                    if (rsp_data.irq !== oldest.irq)
                        flag_field("irq", DATA_W'(oldest.irq), DATA_W'(rsp_data.irq));
                end
            end
            if (req_valid && req_ready)
                expected_rsp.push_back(predict_response(req_data));
        end
        failures <= fail_total;
        pending  <= expected_rsp.size();
        checked  <= compared;
    end

endmodule

// ===== verif/multichannel_timer_registers_top_test.sv =====
`timescale 1ns / 1ps
// Testbench top for the multichannel timer: generates requests and back-pressure and reports the verdict.
module multichannel_timer_registers_top_test;
    import mtr_pkg::*;

    localparam logic [KIND_W-1:0] KIND_RESERVED = 2'd3;
    localparam int                RANDOM_ITEMS  = 1800;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    req_t req_data  = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    rsp_t rsp_data;
    logic calm      = 1'b0;
    int   failures;
    int   pending;
    int   checked;
    int   sent [4] = '{default: 0};

    multichannel_timer_registers_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data)
    );

    timer_register_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data),
        .failures  (failures),
        .pending   (pending),
        .checked   (checked)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
        rsp_ready <= calm || ($urandom_range(0, 99) >= 20);

    initial
    begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic logic [ADDR_W-1:0] chan_addr(int ch, logic [3:0] sel);
        return CHAN_BASE + ADDR_W'(ch * 16) + ADDR_W'(sel);
    endfunction

    function automatic logic [ADDR_W-1:0] pick_register();
        int pick;
        int ch;
        pick = $urandom_range(0, 9);
        ch   = $urandom_range(0, NUM_CHANNELS - 1);
        case (pick)
            0: return REG_DEST;
            1: return REG_STATUS;
            2: return REG_INTEN;
            3: return REG_CLKDIV;
            4, 5: return chan_addr(ch, CHAN_REG_CTRL);
            6, 7: return chan_addr(ch, CHAN_REG_TARGET);
            default: return chan_addr(ch, CHAN_REG_COUNT);
        endcase
    endfunction

    task automatic send(logic [KIND_W-1:0] kind, logic [ADDR_W-1:0] addr,
                        logic [DATA_W-1:0] data);
        req_valid <= 1'b1;
        req_data  <= '{kind: kind, address: addr, write_data: data};
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        sent[kind] += 1;
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    initial
    begin
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
        int                pick;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: register masks, both channel modes, divider, odd addresses.
        send(KIND_WRITE, REG_DEST, '1);
        send(KIND_READ, REG_DEST, '0);
        send(KIND_WRITE, REG_INTEN, '1);
        send(KIND_WRITE, REG_CLKDIV, '1);
        send(KIND_READ, REG_CLKDIV, '0);
        send(KIND_WRITE, REG_CLKDIV, (DATA_W'(1) << DIV_ON_BIT) | (DATA_W'(1) << DIV_LSB));
        send(KIND_WRITE, chan_addr(0, CHAN_REG_TARGET), '0);
        send(KIND_WRITE, chan_addr(0, CHAN_REG_CTRL), 32'h3);
        send(KIND_TICK, '0, '0);
        send(KIND_READ, REG_STATUS, '0);
        send(KIND_WRITE, REG_STATUS, '1);
        send(KIND_WRITE, chan_addr(NUM_CHANNELS - 1, CHAN_REG_TARGET), 32'd2);
        send(KIND_WRITE, chan_addr(NUM_CHANNELS - 1, CHAN_REG_CTRL), 32'h5);
        repeat (5) send(KIND_TICK, '1, '1);
        send(KIND_WRITE, chan_addr(NUM_CHANNELS - 1, CHAN_REG_COUNT), '1);
        send(KIND_READ, chan_addr(NUM_CHANNELS - 1, CHAN_REG_COUNT), '0);
        send(KIND_READ, CHAN_BASE | ADDR_W'(1), '0);
        send(KIND_WRITE, REG_CLKDIV + ADDR_W'(4), '1);
        send(KIND_READ, chan_addr(NUM_CHANNELS, CHAN_REG_CTRL), '0);
        send(KIND_READ, chan_addr(0, 4'hC), '0);
        send(KIND_RESERVED, '1, '1);
        send(KIND_WRITE, REG_CLKDIV, '0);
        drain();

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == 700)
                calm <= 1'b1;
            if (i == 1000)
                calm <= 1'b0;
            if (i == 1200)
                drain();
            if (!calm && $urandom_range(0, 99) < 20)
            begin
                req_valid <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge clk);
            end
            pick = $urandom_range(0, 99);
            if (pick < 40)
                send(KIND_TICK, ADDR_W'($urandom()), $urandom());
            else if (pick < 60)
                send(KIND_READ, pick_register(), $urandom());
            else if (pick < 88)
            begin
                addr = pick_register();
                data = $urandom();
                if (addr == REG_CLKDIV)
                begin
                    if ($urandom_range(0, 9) != 0)
                        data[DIV_LSB +: RATIO_W] = RATIO_W'($urandom_range(0, 3));
                    data[DIV_ON_BIT] = ($urandom_range(0, 9) != 0);
                end
                else if (addr >= CHAN_BASE && addr[3:0] == CHAN_REG_TARGET)
                begin
                    if ($urandom_range(0, 9) != 0)
                        data = DATA_W'($urandom_range(0, 12));
                end
                else if (addr >= CHAN_BASE && addr[3:0] == CHAN_REG_CTRL)
                    data[0] = ($urandom_range(0, 3) != 0);
                send(KIND_WRITE, addr, data);
            end
            else
                send(KIND_W'($urandom_range(0, 3)), ADDR_W'($urandom()), $urandom());
        end

        drain();
        repeat (6) @(posedge clk);

        $display("Sent %0d ticks, %0d reads, %0d writes and %0d reserved-kind requests.",
                 sent[KIND_TICK], sent[KIND_READ], sent[KIND_WRITE], sent[KIND_RESERVED]);
        $display("Compared %0d responses over periodic, one-shot and divided channels.",
                 checked);
        if (failures == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== multichannel_timer_registers_top.f =====
hw/rtl/mtr_pkg.sv
hw/rtl/mtr_channel.sv
hw/rtl/multichannel_timer_registers_top.sv
verif/timer_register_checker.sv
verif/multichannel_timer_registers_top_test.sv
